@@ rtl/sha512_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 package
// Shared types, constants and round functions for the streaming hasher.
// ---------------------------------------------------------------------------
package sha512_pkg;

    typedef logic [63:0] word_t;

    localparam int unsigned NumRounds = 80;

    typedef struct packed {
        logic load_word;   // write assembled word into schedule slot
        logic start_round; // load working vars from chain
        logic do_round;    // one compression round
        logic finish;      // add working vars into chain
        logic reset_chain; // restore initial hash
        logic [6:0] round; // round index
    } dp_cmd_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        r = '0;
        unique case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [6:0] i);
        word_t r;
        r = '0;
        unique case (i)
            7'd0: r = 64'h428a2f98d728ae22;   7'd1: r = 64'h7137449123ef65cd;
            7'd2: r = 64'hb5c0fbcfec4d3b2f;   7'd3: r = 64'he9b5dba58189dbbc;
            7'd4: r = 64'h3956c25bf348b538;   7'd5: r = 64'h59f111f1b605d019;
            7'd6: r = 64'h923f82a4af194f9b;   7'd7: r = 64'hab1c5ed5da6d8118;
            7'd8: r = 64'hd807aa98a3030242;   7'd9: r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c;  7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f;  7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235;  7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2;  7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5;  7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275;  7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4;  7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab;  7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f;  7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2;  7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f;  7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc;  7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed;  7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de;  7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6;  7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364;  7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791;  7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218;  7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a;  7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8;  7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99;  7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63;  7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373;  7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc;  7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72;  7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28;  7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915;  7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c;  7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e;  7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba;  7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae;  7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84;  7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc;  7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6;  7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec;  7'd79: r = 64'h6c44198c4a475817;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ rtl/sha512_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 channel interfaces
// Valid/ready channels for message input and digest output.
// ---------------------------------------------------------------------------
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        is_last;
    modport source (output valid, data_word, byte_count, is_last, input ready);
    modport sink (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sha512_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 datapath
// Message schedule window, working variables and chain value.
// ---------------------------------------------------------------------------
module sha512_datapath
    import sha512_pkg::*;
(
    input  logic       clk,
    input  dp_cmd_t    cmd,
    input  word_t      word_in,
    input  logic [2:0] read_index,
    output word_t      chain_word
);

    word_t w_reg [16];
    word_t h_reg [8];
    word_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    word_t w_cur, w_new, t1, t2, s0, s1;

    // schedule: 16-entry window shifted once per loaded word and once per round
    always_comb
    begin
        s0    = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1    = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = hh_reg + (rotr(e_reg, 14) ^ rotr(e_reg, 18) ^ rotr(e_reg, 41))
             + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(cmd.round) + w_cur;
        t2 = (rotr(a_reg, 28) ^ rotr(a_reg, 34) ^ rotr(a_reg, 39))
             + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word || cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= cmd.load_word ? word_in : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_round)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2]; d_reg <= h_reg[3];
            e_reg <= h_reg[4]; f_reg <= h_reg[5]; g_reg <= h_reg[6]; hh_reg <= h_reg[7];
        end
        else if (cmd.do_round)
        begin
            hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reset_chain)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else if (cmd.finish)
        begin
            h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg; h_reg[5] <= h_reg[5] + f_reg;
            h_reg[6] <= h_reg[6] + g_reg; h_reg[7] <= h_reg[7] + hh_reg;
        end
    end

    assign chain_word = h_reg[read_index];

endmodule

@@ rtl/sha512_control.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 controller
// Byte packing, padding sequence, round counter and digest readout.
// ---------------------------------------------------------------------------
module sha512_control
    import sha512_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sha512_in_if.sink      in_ch,
    sha512_out_if.source   out_ch,
    output dp_cmd_t        cmd,
    output word_t          word_out,
    output logic [2:0]     read_index,
    input  word_t          chain_word
);

    localparam logic [2:0] S_BOOT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [6:0]   round_reg, round_next;
    logic [2:0]   pos_reg, pos_next;        // bytes in the partial word
    logic [3:0]   widx_reg, widx_next;      // words in block
    logic [63:0]  part_reg, part_next;
    logic [63:0]  len_reg, len_next;
    logic         padding_reg, padding_next; // in padding phase
    logic         mark_reg, mark_next;       // 0x80 already placed
    logic         late_reg, late_next;       // 0x80 landed in the length words
    logic [2:0]   oidx_reg, oidx_next;
    // length was written when the last word of a padded block was the length
    logic         lenw_reg, lenw_next;

    logic [3:0]   cnt;
    logic [63:0]  shifted, merged;
    logic [4:0]   total;
    logic         accept;
    word_t        full_word;
    logic         emit_word;
    logic [63:0]  spill;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign cnt         = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;

    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_word = chain_word;
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = (oidx_reg == 3'd7);
    assign read_index         = oidx_reg;

    always_comb
    begin
        logic [63:0] mask;
        mask    = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
        shifted = (in_ch.data_word & mask) >> {pos_reg, 3'b000};
        spill   = (pos_reg == 3'd0) ? 64'd0
                : ((in_ch.data_word & mask) << {3'd0 - pos_reg, 3'b000});
        merged  = part_reg | shifted;
        total   = {2'b00, pos_reg} + {1'b0, cnt};
    end

    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        pos_next     = pos_reg;
        widx_next    = widx_reg;
        part_next    = part_reg;
        len_next     = len_reg;
        padding_next = padding_reg;
        mark_next    = mark_reg;
        late_next    = late_reg;
        oidx_next    = oidx_reg;
        cmd          = '0;
        cmd.round    = round_reg;
        full_word    = merged;
        emit_word    = 1'b0;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.reset_chain = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    len_next = len_reg + {57'd0, cnt, 3'b000};
                    if (total >= 5'd8)
                    begin
                        emit_word = 1'b1;
                        full_word = merged;
                        part_next = spill;
                        pos_next  = 3'(total - 5'd8);
                    end
                    else
                    begin
                        part_next = merged;
                        pos_next  = 3'(total);
                    end
                    if (in_ch.is_last)
                        padding_next = 1'b1;
                    if (emit_word && widx_reg == 4'd15)
                        state_next = S_ROUND;
                    else if (in_ch.is_last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // one word per cycle: partial+0x80, zeros, then length
                emit_word = 1'b1;
                if (!mark_reg)
                begin
                    full_word = part_reg | (64'h80 << {3'd7 - pos_reg, 3'b000});
                    mark_next = 1'b1;
                    part_next = '0;
                    pos_next  = '0;
                    if (widx_reg >= 4'd14)
                        late_next = 1'b1;
                end
                else if (widx_reg == 4'd15 && !late_reg)
                    full_word = len_reg;
                else
                    full_word = '0;
                if (widx_reg == 4'd15)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(NumRounds - 1))
                begin
                    round_next = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                late_next  = 1'b0;
                if (!padding_reg)
                    state_next = S_IDLE;
                else if (mark_reg && widx_reg == 4'd0 && lenw_reg)
                    state_next = S_OUT;
                else
                    state_next = S_PAD;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next      = S_BOOT;
                        len_next        = '0;
                        padding_next    = 1'b0;
                        mark_next       = 1'b0;
                        pos_next        = '0;
                        part_next       = '0;
                    end
                end
            end
            default: state_next = S_BOOT;
        endcase
        if (emit_word)
        begin
            cmd.load_word = 1'b1;
            widx_next = widx_reg + 4'd1;
        end
        if (state_next == S_ROUND && state_reg != S_ROUND)
            cmd.start_round = 1'b1;
    end

    always_comb
    begin
        lenw_next = lenw_reg;
        if (state_reg == S_PAD && mark_reg && widx_reg == 4'd15 && !late_reg)
            lenw_next = 1'b1;
        if (state_reg == S_PAD && !mark_reg && widx_reg == 4'd15)
            lenw_next = 1'b0;
        if (state_reg == S_OUT)
            lenw_next = 1'b0;
    end

    assign word_out = full_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_BOOT;
            round_reg   <= '0;
            pos_reg     <= '0;
            widx_reg    <= '0;
            part_reg    <= '0;
            len_reg     <= '0;
            padding_reg <= 1'b0;
            mark_reg    <= 1'b0;
            late_reg    <= 1'b0;
            oidx_reg    <= '0;
            lenw_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            pos_reg     <= pos_next;
            widx_reg    <= widx_next;
            part_reg    <= part_next;
            len_reg     <= len_next;
            padding_reg <= padding_next;
            mark_reg    <= mark_next;
            late_reg    <= late_next;
            oidx_reg    <= oidx_next;
            lenw_reg    <= lenw_next;
        end
    end

endmodule

@@ rtl/sha512_stream_hasher.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream hasher
// Streaming SHA-512: packs bytes into 128-byte blocks, compresses, pads.
// ---------------------------------------------------------------------------
// Input items are packed into words as they arrive; a completed block runs
// 80 rounds at one per cycle in the shared round unit, then the chain update,
// and no new item is taken until it is done.
// Last item: up to 18 padding words and one or two compressions, then
// eight digest transfers. Reset is asynchronous; after reset the boot state
// loads the chain value with the initial hash, then the block is ready.
module sha512_stream_hasher
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);

    dp_cmd_t    cmd;
    word_t      word_bus;
    word_t      chain_word;
    logic [2:0] read_index;

    sha512_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cmd        (cmd),
        .word_out   (word_bus),
        .read_index (read_index),
        .chain_word (chain_word)
    );

    sha512_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .word_in    (word_bus),
        .read_index (read_index),
        .chain_word (chain_word)
    );

endmodule

@@ rtl/sha512_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 port checker
// Concurrent checks on the top-level channel behavior.
// ---------------------------------------------------------------------------
module sha512_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word))
        else $error("digest changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during digest readout");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid &&
        word_index == $past(word_index) + 3'd1)
        else $error("digest index skipped");

endmodule

bind sha512_stream_hasher sha512_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
);

@@ tb/sha512_tb_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 testbench channel binding
// The block's own channel interfaces are reused; this file only gathers the
// testbench-side message and digest types of the stimulus and digest queues.
// ---------------------------------------------------------------------------
package sha512_tb_pkg;

    typedef struct {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        is_last;
    } msg_item_t;

    typedef struct {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

endpackage

@@ tb/sha512_stream_hasher_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Feeds byte-packed messages with random valid/ready gaps, hashes them with
// an in-bench SHA-512 model and checks every digest transfer in order.
// ---------------------------------------------------------------------------
module sha512_stream_hasher_tb;
    import sha512_pkg::*;
    import sha512_tb_pkg::*;

    localparam int unsigned IdlePct = 35;

    logic clk;
    logic rst_n;

    sha512_in_if  in_ch ();
    sha512_out_if out_ch ();

    sha512_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    msg_item_t    pending_msgs[$];
    digest_item_t expected_digests[$];
    int           fail_count;
    bit           no_idle;
    bit           stim_done;

    logic [63:0] hash_state[8];
    logic [63:0] msg_block[16];
    logic [6:0]  block_fill;
    logic [63:0] msg_bits;

    localparam logic [63:0] IV[8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] KTAB[80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        block_fill = '0;
        msg_bits   = '0;
    endtask

    task automatic compress_msg_block();
        logic [63:0] w[80];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 16; i < 80; i++)
        begin
            s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 80; i++)
        begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
                 + KTAB[i] + w[i];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic absorb_byte(logic [7:0] v);
        int unsigned wi;
        int unsigned sh;
        wi = block_fill[6:3];
        sh = 56 - 8 * block_fill[2:0];
        msg_block[wi] = (msg_block[wi] & ~(64'hff << sh)) | (64'(v) << sh);
        block_fill = block_fill + 7'd1;
        if (block_fill == 7'd0)
            compress_msg_block();
    endtask

    task automatic predict_digest(msg_item_t it);
        int unsigned n;
        digest_item_t d;
        n = (it.byte_count > 4'd8) ? 8 : it.byte_count;
        for (int i = 0; i < n; i++)
            absorb_byte(it.data_word[63 - 8*i -: 8]);
        msg_bits = msg_bits + 64'(n * 8);
        if (!it.is_last)
            return;
        absorb_byte(8'h80);
        while (block_fill != 7'd112)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_byte(msg_bits[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            expected_digests.push_back(d);
        end
        hash_restart();
    endtask

    function automatic msg_item_t make_item(logic [63:0] dw, logic [3:0] bc, logic lst);
        msg_item_t it;
        it.data_word  = dw;
        it.byte_count = bc;
        it.is_last    = lst;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random message: mostly full words, length spread around block edges.
    task automatic queue_random_message(int unsigned nbytes);
        int unsigned left;
        int unsigned bc;
        left = nbytes;
        while (left > 8)
        begin
            bc = ($urandom_range(0, 9) < 8) ? 8 : $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0)
                bc = $urandom_range(9, 15);
            if (bc >= 8 && left >= 8)
                left -= 8;
            else if (bc < 8)
                left -= bc;
            pending_msgs.push_back(make_item(rand64(), 4'(bc), 1'b0));
        end
        pending_msgs.push_back(make_item(rand64(), 4'(left), 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[sha512_stream_hasher] ERROR");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_word  = '0;
        in_ch.byte_count = '0;
        in_ch.is_last    = 1'b0;
        out_ch.ready     = 1'b0;
        fail_count = 0;
        no_idle    = 1'b0;
        stim_done  = 1'b0;
        hash_restart();

        // directed: empty message, field extremes, oversized count, empty non-last
        pending_msgs.push_back(make_item(64'h0, 4'd0, 1'b1));
        pending_msgs.push_back(make_item(64'h6162630000000000, 4'd3, 1'b1));
        pending_msgs.push_back(make_item(64'hffffffffffffffff, 4'd15, 1'b0));
        pending_msgs.push_back(make_item(64'h0123456789abcdef, 4'd0, 1'b0));
        pending_msgs.push_back(make_item(64'hffffffffffffffff, 4'd8, 1'b1));
        pending_msgs.push_back(make_item(64'h0, 4'd8, 1'b0));
        pending_msgs.push_back(make_item(64'haaaaaaaaaaaaaaaa, 4'd9, 1'b1));
        // 111 and 112 byte messages straddle the padding boundary
        for (int m = 0; m < 2; m++)
        begin
            for (int i = 0; i < 13; i++)
                pending_msgs.push_back(make_item(rand64(), 4'd8, 1'b0));
            pending_msgs.push_back(make_item(64'h5555555555555555, 4'(7 + m), 1'b1));
        end

        for (int m = 0; m < 13; m++)
        begin
            case ($urandom_range(0, 3))
                0: queue_random_message($urandom_range(0, 20));
                1: queue_random_message($urandom_range(104, 136));
                2: queue_random_message($urandom_range(0, 260));
                default: queue_random_message(128 * $urandom_range(0, 1) + 111 +
                                              $urandom_range(0, 2));
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        stim_done = 1'b1;
    end

    // idle-free stretch in the middle of the run
    always @(posedge clk)
        no_idle <= (pending_msgs.size() > 60 && pending_msgs.size() < 120);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_digest(make_item(in_ch.data_word, in_ch.byte_count, in_ch.is_last));
                void'(pending_msgs.pop_front());
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_msgs.size() > 0
                    && (no_idle || $urandom_range(0, 99) >= IdlePct))
                begin
                    in_ch.valid      <= 1'b1;
                    in_ch.data_word  <= pending_msgs[0].data_word;
                    in_ch.byte_count <= pending_msgs[0].byte_count;
                    in_ch.is_last    <= pending_msgs[0].is_last;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    always @(posedge clk)
    begin
        digest_item_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $error("unexpected digest transfer: digest_word %h", out_ch.digest_word);
                fail_count++;
            end
            else
            begin
                e = expected_digests.pop_front();
                if (out_ch.digest_word !== e.digest_word)
                begin
                    $error("digest_word exp %h got %h", e.digest_word, out_ch.digest_word);
                    fail_count++;
                end
                if (out_ch.word_index !== e.word_index)
                begin
                    $error("word_index exp %0d got %0d", e.word_index, out_ch.word_index);
                    fail_count++;
                end
                if (out_ch.last_word !== e.last_word)
                begin
                    $error("last_word exp %0d got %0d", e.last_word, out_ch.last_word);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && rst_n);
        wait (pending_msgs.size() == 0 && !in_ch.valid);
        wait (expected_digests.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && expected_digests.size() == 0)
            $display("[sha512_stream_hasher] OK");
        else
            $display("[sha512_stream_hasher] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sha512_pkg.sv
rtl/sha512_if.sv
rtl/sha512_datapath.sv
rtl/sha512_control.sv
rtl/sha512_stream_hasher.sv
rtl/sha512_checker.sv
tb/sha512_tb_if.sv
tb/sha512_stream_hasher_tb.sv
